@@ rtl/rlsk_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray line and slab key package
// Shared widths, register indexes, error codes and the direction type.
// ----------------------------------------------------------------------------
`default_nettype none

package rlsk_pkg;

  localparam int unsigned AXIS_BITS_DEF = 10;

  localparam int unsigned ID_W       = 30;
  localparam int unsigned GRID_W     = 11;
  localparam int unsigned SIGN_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned LINE_W = 23;
  localparam int unsigned SLAB_W = 13;
  localparam int unsigned RANK_W = 12;
  localparam int unsigned BAD_W  = 2;

  // Quotient bits resolved by one divider stage.
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [GRID_W-1:0] GRID_RST   = GRID_W'(1);
  localparam logic [SIGN_W-1:0] SIGN_X_RST = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_YZ_RST = 2'b00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X = 3'd0,
    REG_GRID_Y = 3'd1,
    REG_GRID_Z = 3'd2,
    REG_SIGN_X = 3'd3,
    REG_SIGN_Y = 3'd4,
    REG_SIGN_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [BAD_W-1:0] {
    BAD_NONE   = 2'd0,
    BAD_NO_DIR = 2'd1,
    BAD_RANGE  = 2'd2
  } bad_e;

  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] neg;
  } dir_t;

endpackage

`default_nettype wire

@@ rtl/rlsk_cfg.sv @@
// ----------------------------------------------------------------------------
// Ray line and slab key configuration registers
// Holds grid sizes and direction signs and presents their effective values.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsk_cfg import rlsk_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  output logic [2:0][AXIS_BITS:0]     size_o,
  output dir_t                        dir_o
);

  localparam int unsigned SIZE_W = AXIS_BITS + 1;
  localparam int unsigned CMP_W  = (SIZE_W > GRID_W) ? SIZE_W : GRID_W;
  localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'(1) << AXIS_BITS;

  logic [2:0][GRID_W-1:0] grid_q;
  logic [2:0][SIGN_W-1:0] sign_q;
  logic [CMP_W-1:0]       raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= {GRID_RST, GRID_RST, GRID_RST};
      sign_q <= {SIGN_YZ_RST, SIGN_YZ_RST, SIGN_X_RST};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GRID_X: begin
          grid_q[0] <= cfg_data_i[GRID_W-1:0];
        end
        REG_GRID_Y: begin
          grid_q[1] <= cfg_data_i[GRID_W-1:0];
        end
        REG_GRID_Z: begin
          grid_q[2] <= cfg_data_i[GRID_W-1:0];
        end
        REG_SIGN_X: begin
          sign_q[0] <= cfg_data_i[SIGN_W-1:0];
        end
        REG_SIGN_Y: begin
          sign_q[1] <= cfg_data_i[SIGN_W-1:0];
        end
        REG_SIGN_Z: begin
          sign_q[2] <= cfg_data_i[SIGN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A size of zero acts as one and sizes beyond the axis range are clamped.
  always_comb begin
    raw = '0;
    for (int k = 0; k < 3; k++) begin
      raw = CMP_W'(grid_q[k]);
      if (raw == '0) begin
        size_o[k] = SIZE_W'(1);
      end else if (raw > SIZE_MAX) begin
        size_o[k] = SIZE_MAX[SIZE_W-1:0];
      end else begin
        size_o[k] = raw[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_o.pos[k] = (sign_q[k] == 2'b01);
      dir_o.neg[k] = sign_q[k][1];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rlsk_split.sv @@
// ----------------------------------------------------------------------------
// Ray line and slab key coordinate splitter
// Pipelined restoring division of the cell index by the x size, then of the
// quotient by the y size, a few quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsk_split import rlsk_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [ID_W-1:0]       cell_id_i,
  input  logic [AXIS_BITS:0]    size_x_i,
  input  logic [AXIS_BITS:0]    size_y_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [AXIS_BITS-1:0]  coord_x_o,
  output logic [AXIS_BITS-1:0]  coord_y_o,
  output logic [ID_W-1:0]       quot_o
);

  localparam int unsigned SIZE_W = AXIS_BITS + 1;
  localparam int unsigned SPD    = (ID_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned NST    = 2 * SPD;

  logic                 v_q    [NST];
  logic                 en     [NST];
  logic [ID_W-1:0]      work_q [NST];
  logic [AXIS_BITS-1:0] rem_q  [NST];
  logic [AXIS_BITS-1:0] x_q    [NST];

  function automatic logic [ID_W+AXIS_BITS-1:0] div_steps(
    input logic [ID_W-1:0]      work,
    input logic [AXIS_BITS-1:0] rem,
    input logic [SIZE_W-1:0]    dvs,
    input int unsigned          nsteps
  );
    logic [ID_W-1:0]      w;
    logic [AXIS_BITS-1:0] r;
    logic [SIZE_W-1:0]    trial;
    logic                 fit;
    w = work;
    r = rem;
    for (int unsigned i = 0; i < DIV_STEPS; i++) begin
      if (i < nsteps) begin
        trial = {r, w[ID_W-1]};
        fit   = (trial >= dvs);
        w     = {w[ID_W-2:0], fit};
        if (fit) begin
          trial = trial - dvs;
        end
        r = trial[AXIS_BITS-1:0];
      end
    end
    return {w, r};
  endfunction

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int unsigned STEP_BASE = (k % SPD) * DIV_STEPS;
    localparam int unsigned NSTEP =
      ((ID_W - STEP_BASE) < DIV_STEPS) ? (ID_W - STEP_BASE) : DIV_STEPS;

    logic                 v_in;
    logic                 en_next;
    logic [ID_W-1:0]      work_in;
    logic [AXIS_BITS-1:0] rem_in;
    logic [AXIS_BITS-1:0] x_in;
    logic [SIZE_W-1:0]    dvs;
    logic [ID_W-1:0]      work_d;
    logic [AXIS_BITS-1:0] rem_d;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign work_in = cell_id_i;
      assign rem_in  = '0;
      assign x_in    = '0;
    end else if (k == SPD) begin : g_mid
      // The first remainder is the x coordinate; the quotient is divided again.
      assign v_in    = v_q[k-1];
      assign work_in = work_q[k-1];
      assign rem_in  = '0;
      assign x_in    = rem_q[k-1];
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign work_in = work_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign x_in    = x_q[k-1];
    end

    if (k == NST - 1) begin : g_last
      assign en_next = !stall_i;
    end else begin : g_inner
      assign en_next = en[k+1];
    end

    assign dvs   = (k < SPD) ? size_x_i : size_y_i;
    assign en[k] = !v_q[k] || en_next;
    assign {work_d, rem_d} = div_steps(work_in, rem_in, dvs, NSTEP);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_in) begin
        work_q[k] <= work_d;
        rem_q[k]  <= rem_d;
        x_q[k]    <= x_in;
      end
    end
  end

  assign stall_o   = !en[0];
  assign valid_o   = v_q[NST-1];
  assign coord_x_o = x_q[NST-1];
  assign coord_y_o = rem_q[NST-1];
  assign quot_o    = work_q[NST-1];

endmodule

`default_nettype wire

@@ rtl/rlsk_key.sv @@
// ----------------------------------------------------------------------------
// Ray line and slab key generator
// Four stages: per-axis terms and range check, key operands, product, and the
// output register with the final line key sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsk_key import rlsk_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [AXIS_BITS-1:0]     coord_x_i,
  input  logic [AXIS_BITS-1:0]     coord_y_i,
  input  logic [ID_W-1:0]          quot_i,
  input  logic [2:0][AXIS_BITS:0]  size_i,
  input  dir_t                     dir_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [LINE_W-1:0]        line_key_o,
  output logic signed [SLAB_W-1:0] slab_index_o,
  output logic [RANK_W-1:0]        travel_rank_o,
  output logic [BAD_W-1:0]         bad_request_o
);

  localparam int unsigned SIZE_W = AXIS_BITS + 1;
  localparam int unsigned SW     = AXIS_BITS + 3;
  localparam int unsigned MA_W   = AXIS_BITS + 2;
  localparam int unsigned PW     = 2 * SW;

  // Stage 1.
  logic                               v1_q;
  logic [2:0][AXIS_BITS-1:0]          c1_q;
  logic signed [AXIS_BITS:0]          sc1_q [3];
  logic [2:0][AXIS_BITS-1:0]          rk1_q;
  bad_e                               bad1_q;
  logic [2:0][AXIS_BITS-1:0]          c_in;
  logic signed [AXIS_BITS:0]          sc_d  [3];
  logic [2:0][AXIS_BITS-1:0]          rk_d;
  logic [2:0][SIZE_W-1:0]             rk_diff;
  bad_e                               bad_d;

  // Stage 2.
  logic                               v2_q;
  logic signed [SW-1:0]               base2_q, mulb2_q, slab2_q;
  logic [MA_W-1:0]                    mula2_q;
  logic [MA_W-1:0]                    rank2_q;
  bad_e                               bad2_q;
  logic signed [SW-1:0]               base_d, mulb_d, slab_d;
  logic [MA_W-1:0]                    mula_d, rank_d;

  // Stage 3.
  logic                               v3_q;
  logic signed [PW-1:0]               prod3_q;
  logic signed [SW-1:0]               base3_q, slab3_q;
  logic [MA_W-1:0]                    rank3_q;
  bad_e                               bad3_q;

  // Stage 4, the output register.
  logic                               v4_q;
  logic [LINE_W-1:0]                  line4_q;
  logic signed [SLAB_W-1:0]           slab4_q;
  logic [RANK_W-1:0]                  rank4_q;
  bad_e                               bad4_q;
  logic signed [PW:0]                 line_sum;

  logic en1, en2, en3, en4;

  function automatic logic signed [SW-1:0] zc(input logic [AXIS_BITS-1:0] c);
    return $signed({3'b000, c});
  endfunction

  function automatic logic signed [SW-1:0] se(input logic signed [AXIS_BITS:0] s);
    return $signed({{2{s[AXIS_BITS]}}, s});
  endfunction

  function automatic logic signed [SW-1:0] offs(
    input logic signed [AXIS_BITS:0] s_hi,
    input logic signed [AXIS_BITS:0] s_lo,
    input logic [SIZE_W-1:0]         n_lo
  );
    return se(s_hi) - se(s_lo) + $signed({2'b00, n_lo});
  endfunction

  function automatic logic [MA_W-1:0] nsum(
    input logic [SIZE_W-1:0] n_a,
    input logic [SIZE_W-1:0] n_b
  );
    return {1'b0, n_a} + {1'b0, n_b};
  endfunction

  assign en4     = !v4_q || !stall_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  always_comb begin
    c_in[0] = coord_x_i;
    c_in[1] = coord_y_i;
    c_in[2] = quot_i[AXIS_BITS-1:0];
    for (int k = 0; k < 3; k++) begin
      if (dir_i.pos[k]) begin
        sc_d[k] = $signed({1'b0, c_in[k]});
      end else if (dir_i.neg[k]) begin
        sc_d[k] = -$signed({1'b0, c_in[k]});
      end else begin
        sc_d[k] = '0;
      end
      rk_diff[k] = size_i[k] - SIZE_W'(1) - {1'b0, c_in[k]};
      rk_d[k]    = dir_i.neg[k] ? rk_diff[k][AXIS_BITS-1:0] : c_in[k];
    end
    // The cell lies outside the grid when its z quotient reaches the z size.
    if (quot_i >= ID_W'(size_i[2])) begin
      bad_d = BAD_RANGE;
    end else if ((dir_i.pos | dir_i.neg) == 3'b000) begin
      bad_d = BAD_NO_DIR;
    end else begin
      bad_d = BAD_NONE;
    end
  end

  // The case selects on the mask of axes with a nonzero sign.
  always_comb begin
    base_d = '0;
    mula_d = '0;
    mulb_d = '0;
    case (dir_i.pos | dir_i.neg)
      3'b001: begin
        base_d = zc(c1_q[1]);
        mula_d = MA_W'(size_i[1]);
        mulb_d = zc(c1_q[2]);
      end
      3'b010: begin
        base_d = zc(c1_q[2]);
        mula_d = MA_W'(size_i[2]);
        mulb_d = zc(c1_q[0]);
      end
      3'b100: begin
        base_d = zc(c1_q[0]);
        mula_d = MA_W'(size_i[0]);
        mulb_d = zc(c1_q[1]);
      end
      3'b011: begin
        base_d = offs(sc1_q[1], sc1_q[0], size_i[0]);
        mula_d = nsum(size_i[0], size_i[1]);
        mulb_d = zc(c1_q[2]);
      end
      3'b101: begin
        base_d = offs(sc1_q[2], sc1_q[0], size_i[0]);
        mula_d = nsum(size_i[0], size_i[2]);
        mulb_d = zc(c1_q[1]);
      end
      3'b110: begin
        base_d = offs(sc1_q[2], sc1_q[1], size_i[1]);
        mula_d = nsum(size_i[1], size_i[2]);
        mulb_d = zc(c1_q[0]);
      end
      3'b111: begin
        base_d = offs(sc1_q[1], sc1_q[0], size_i[0]);
        mula_d = nsum(size_i[0], size_i[1]);
        mulb_d = offs(sc1_q[2], sc1_q[1], size_i[1]);
      end
      default: begin
        base_d = '0;
        mula_d = '0;
        mulb_d = '0;
      end
    endcase
    slab_d = se(sc1_q[0]) + se(sc1_q[1]) + se(sc1_q[2]);
    rank_d = {2'b00, rk1_q[0]} + {2'b00, rk1_q[1]} + {2'b00, rk1_q[2]};
  end

  assign line_sum = (PW + 1)'(base3_q) + (PW + 1)'(prod3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      c1_q   <= c_in;
      sc1_q  <= sc_d;
      rk1_q  <= rk_d;
      bad1_q <= bad_d;
    end
    if (en2 && v1_q) begin
      base2_q <= base_d;
      mula2_q <= mula_d;
      mulb2_q <= mulb_d;
      slab2_q <= slab_d;
      rank2_q <= rank_d;
      bad2_q  <= bad1_q;
    end
    if (en3 && v2_q) begin
      prod3_q <= $signed({1'b0, mula2_q}) * mulb2_q;
      base3_q <= base2_q;
      slab3_q <= slab2_q;
      rank3_q <= rank2_q;
      bad3_q  <= bad2_q;
    end
    if (en4 && v3_q) begin
      bad4_q <= bad3_q;
      if (bad3_q == BAD_NONE) begin
        line4_q <= LINE_W'(line_sum);
        slab4_q <= SLAB_W'(slab3_q);
        rank4_q <= RANK_W'(rank3_q);
      end else begin
        line4_q <= '0;
        slab4_q <= '0;
        rank4_q <= '0;
      end
    end
  end

  assign valid_o       = v4_q;
  assign line_key_o    = line4_q;
  assign slab_index_o  = slab4_q;
  assign travel_rank_o = rank4_q;
  assign bad_request_o = bad4_q;

endmodule

`default_nettype wire

@@ rtl/ray_line_slab_key.sv @@
// ----------------------------------------------------------------------------
// Ray line and slab key, top level
// A request carries one linear cell index (x fastest, then y, then z). The
// block splits it into coordinates with the configured grid sizes and returns
// one result per request: the line key of the ray through the cell, the slab
// index along the sweep direction, the travel rank along the ray, and an error
// code for an all-zero direction or a cell index outside the grid.
// Both channels use valid and stall; a request moves at an edge where valid
// is high and stall is low. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write it only while no request
// is in flight, which the block does not enforce. There are 16 divider stages
// (two 30-bit divisions, up to four quotient bits per stage) and four key
// stages ending in the output register. A new request is taken every cycle
// unless the receiver stalls; then the stages fill up behind the held result
// and the input stalls only once no stage is free. Reset empties the pipeline
// and restores the grid to one cell with the direction along positive x.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_line_slab_key import rlsk_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ID_W-1:0]          cell_id_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LINE_W-1:0]        line_key_o,
  output logic signed [SLAB_W-1:0] slab_index_o,
  output logic [RANK_W-1:0]        travel_rank_o,
  output logic [BAD_W-1:0]         bad_request_o
);

  logic [2:0][AXIS_BITS:0]  size;
  dir_t                     dir;
  logic                     split_valid;
  logic                     key_stall;
  logic [AXIS_BITS-1:0]     coord_x;
  logic [AXIS_BITS-1:0]     coord_y;
  logic [ID_W-1:0]          quot;

  rlsk_cfg #(
    .AXIS_BITS (AXIS_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .size_o      (size),
    .dir_o       (dir)
  );

  rlsk_split #(
    .AXIS_BITS (AXIS_BITS)
  ) u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .cell_id_i (cell_id_i),
    .size_x_i  (size[0]),
    .size_y_i  (size[1]),
    .valid_o   (split_valid),
    .stall_i   (key_stall),
    .coord_x_o (coord_x),
    .coord_y_o (coord_y),
    .quot_o    (quot)
  );

  rlsk_key #(
    .AXIS_BITS (AXIS_BITS)
  ) u_key (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (split_valid),
    .stall_o       (key_stall),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .quot_i        (quot),
    .size_i        (size),
    .dir_i         (dir),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .line_key_o    (line_key_o),
    .slab_index_o  (slab_index_o),
    .travel_rank_o (travel_rank_o),
    .bad_request_o (bad_request_o)
  );

endmodule

`default_nettype wire
